// ===== rtl/rmsa_pkg.sv =====
// ----------------------------------------------------------------------------
// rmsa_pkg
// Shared widths, types and helpers of the ranged moving-sum ammeter.
// ----------------------------------------------------------------------------
package rmsa_pkg;

	localparam int WINDOW_LEN  = 8;
	localparam int PTR_W       = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
	localparam int SAMPLE_W    = 10;
	localparam int SLOT_W      = 7;
	localparam int SLOT_MAX    = 99;
	localparam int TOTAL_W     = $clog2(SLOT_MAX * WINDOW_LEN + 1);
	localparam int SCALE_W     = 6;
	localparam int CURRENT_W   = 16;
	localparam int PROD_W      = (TOTAL_W + SCALE_W > CURRENT_W) ? TOTAL_W + SCALE_W
	                                                             : CURRENT_W + 1;
	localparam int RANGE_W     = 2;
	localparam int GAIN        = 100;
	localparam int GAIN_W      = 7;
	localparam int GAIN_SHIFT  = 10;
	localparam int FULL_UNITS  = 80;
	localparam int SCALED_MAX  = 65535;

	typedef enum logic {
		OP_SAMPLE = 1'b0,
		OP_RANGE  = 1'b1
	} op_t;

	typedef enum logic [RANGE_W-1:0] {
		RANGE_10 = 2'd0,
		RANGE_20 = 2'd1,
		RANGE_40 = 2'd2,
		RANGE_50 = 2'd3
	} range_t;

	typedef struct packed {
		logic               valid;
		logic [TOTAL_W-1:0] total;
		logic [RANGE_W-1:0] range_sel;
	} win_res_t;

	function automatic logic [SCALE_W-1:0] scale_of(input logic [RANGE_W-1:0] r);
		logic [SCALE_W-1:0] s;
		unique case (r)
			RANGE_10: s = SCALE_W'(10);
			RANGE_20: s = SCALE_W'(20);
			RANGE_40: s = SCALE_W'(40);
			RANGE_50: s = SCALE_W'(50);
			default:  s = SCALE_W'(10);
		endcase
		return s;
	endfunction

endpackage

// ===== rtl/rmsa_if.sv =====
// ----------------------------------------------------------------------------
// rmsa_req_if / rmsa_rsp_if
// Valid/ready channels for converter items and ammeter results.
// ----------------------------------------------------------------------------
interface rmsa_req_if;
	logic                          valid;
	logic                          ready;
	logic                          op;
	logic [rmsa_pkg::SAMPLE_W-1:0] sample;
	modport source (output valid, output op, output sample, input ready);
	modport sink   (input valid, input op, input sample, output ready);
endinterface

interface rmsa_rsp_if;
	logic                           valid;
	logic                           ready;
	logic [rmsa_pkg::CURRENT_W-1:0] scaled_current;
	logic                           full_scale;
	logic [rmsa_pkg::RANGE_W-1:0]   range_select;
	modport source (output valid, output scaled_current, output full_scale,
	                output range_select, input ready);
	modport sink   (input valid, input scaled_current, input full_scale,
	                input range_select, output ready);
endinterface

// ===== rtl/ranged_moving_sum_ammeter_top.sv =====
// ----------------------------------------------------------------------------
// ranged_moving_sum_ammeter_top
// Moving-sum ammeter with an eight-slot sample ring and four current ranges.
// ----------------------------------------------------------------------------
// req carries op and sample; op sample scales the reading to 0..99 and
// replaces the oldest ring slot, op range steps the range 10/20/40/50 and
// clears the window. Every req beat gives exactly one rsp beat with the
// window total times the range scale (saturated to 16 bits), the full-scale
// flag (total at least 80) and the range select.
// A req beat is held in the stage-1 registers, then in the result register,
// which drives its rsp beat.
// Throughput: one beat per cycle while rsp is not held; the ring slot goes
// through a RAM read in the accept cycle and is written back in the update
// stage, with the running total updated in that same stage.
// Reset: all control state clears at once; ring slots are marked empty by
// per-slot valid bits, so no clearing pass is needed and req is ready
// directly after reset.
// Stall: when rsp is held, the result register and the update stage both
// hold; at most one more req beat is taken while a result waits, then ready
// drops.
// ----------------------------------------------------------------------------
module ranged_moving_sum_ammeter_top (
	input  logic       clk,
	input  logic       arst_n,
	rmsa_req_if.sink   req,
	rmsa_rsp_if.source rsp
);

	rmsa_pkg::win_res_t             res;
	logic                           out_adv;
	logic                           vld_s2;
	logic [rmsa_pkg::TOTAL_W-1:0]   total_s2;
	logic [rmsa_pkg::RANGE_W-1:0]   range_s2;
	logic [rmsa_pkg::PROD_W-1:0]    prod;

	assign out_adv = !vld_s2 || rsp.ready;

	rmsa_window u_window (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req),
		.adv   (out_adv),
		.res   (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (out_adv) begin
			vld_s2 <= res.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (out_adv && res.valid) begin
			total_s2 <= res.total;
			range_s2 <= res.range_sel;
		end
	end

	assign prod = rmsa_pkg::PROD_W'(total_s2)
	            * rmsa_pkg::PROD_W'(rmsa_pkg::scale_of(range_s2));

	assign rsp.valid          = vld_s2;
	assign rsp.scaled_current = (prod > rmsa_pkg::PROD_W'(rmsa_pkg::SCALED_MAX))
	                          ? rmsa_pkg::CURRENT_W'(rmsa_pkg::SCALED_MAX)
	                          : prod[rmsa_pkg::CURRENT_W-1:0];
	assign rsp.full_scale     = (total_s2 >= rmsa_pkg::TOTAL_W'(rmsa_pkg::FULL_UNITS));
	assign rsp.range_select   = range_s2;

endmodule

// ===== rtl/rmsa_ring_ram.sv =====
// ----------------------------------------------------------------------------
// rmsa_ring_ram
// Simple dual-port RAM, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module rmsa_ring_ram #(
	parameter int DEPTH  = 8,
	parameter int WIDTH  = 7,
	parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [WIDTH-1:0]  wdata,
	input  logic              re,
	input  logic [ADDR_W-1:0] raddr,
	output logic [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== rtl/rmsa_window.sv =====
// ----------------------------------------------------------------------------
// rmsa_window
// Ring slot read-modify-write and running window total.
// ----------------------------------------------------------------------------
module rmsa_window (
	input  logic                 clk,
	input  logic                 arst_n,
	rmsa_req_if.sink             req,
	input  logic                 adv,
	output rmsa_pkg::win_res_t   res
);

	logic                            acc;
	logic                            s1_vld_s1;
	logic                            op_s1;
	logic [rmsa_pkg::SLOT_W-1:0]     scaled_s1;
	logic [rmsa_pkg::PTR_W-1:0]      ptr_s1;
	logic [rmsa_pkg::PTR_W-1:0]      ptr_q;
	logic [rmsa_pkg::PTR_W-1:0]      ptr_nxt;
	logic [rmsa_pkg::TOTAL_W-1:0]    total_q;
	logic [rmsa_pkg::TOTAL_W-1:0]    total_nxt;
	logic [rmsa_pkg::RANGE_W-1:0]    range_q;
	logic [rmsa_pkg::RANGE_W-1:0]    range_nxt;
	logic [rmsa_pkg::WINDOW_LEN-1:0] slot_vld_q;
	logic [rmsa_pkg::SLOT_W-1:0]     rd_data;
	logic [rmsa_pkg::SLOT_W-1:0]     old_slot;
	logic [rmsa_pkg::SAMPLE_W+rmsa_pkg::GAIN_W-1:0] gain_prod;
	logic                            upd;

	assign req.ready = !s1_vld_s1 || adv;
	assign acc       = req.valid && req.ready;
	assign upd       = s1_vld_s1 && adv;

	assign ptr_nxt   = (ptr_q == rmsa_pkg::PTR_W'(rmsa_pkg::WINDOW_LEN - 1))
	                 ? '0 : ptr_q + rmsa_pkg::PTR_W'(1);
	assign gain_prod = (rmsa_pkg::SAMPLE_W+rmsa_pkg::GAIN_W)'(req.sample)
	                 * (rmsa_pkg::SAMPLE_W+rmsa_pkg::GAIN_W)'(rmsa_pkg::GAIN);

	rmsa_ring_ram #(
		.DEPTH (rmsa_pkg::WINDOW_LEN),
		.WIDTH (rmsa_pkg::SLOT_W),
		.ADDR_W(rmsa_pkg::PTR_W)
	) u_ram (
		.clk  (clk),
		.we   (upd && (op_s1 == rmsa_pkg::OP_SAMPLE)),
		.waddr(ptr_s1),
		.wdata(scaled_s1),
		.re   (acc && (req.op == rmsa_pkg::OP_SAMPLE)),
		.raddr(ptr_nxt),
		.rdata(rd_data)
	);

	// slots cleared by a range change read as zero
	assign old_slot = slot_vld_q[ptr_s1] ? rd_data : '0;

	always_comb begin
		if (op_s1 == rmsa_pkg::OP_RANGE) begin
			total_nxt = '0;
			range_nxt = range_q + rmsa_pkg::RANGE_W'(1);
		end else begin
			total_nxt = total_q - rmsa_pkg::TOTAL_W'(old_slot)
			          + rmsa_pkg::TOTAL_W'(scaled_s1);
			range_nxt = range_q;
		end
	end

	assign res.valid     = s1_vld_s1;
	assign res.total     = total_nxt;
	assign res.range_sel = range_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_vld_s1  <= 1'b0;
			ptr_q      <= '0;
			total_q    <= '0;
			range_q    <= '0;
			slot_vld_q <= '0;
		end else begin
			if (acc) begin
				s1_vld_s1 <= 1'b1;
			end else if (adv) begin
				s1_vld_s1 <= 1'b0;
			end
			if (acc && (req.op == rmsa_pkg::OP_SAMPLE)) begin
				ptr_q <= ptr_nxt;
			end
			if (upd) begin
				total_q <= total_nxt;
				range_q <= range_nxt;
				if (op_s1 == rmsa_pkg::OP_RANGE) begin
					slot_vld_q <= '0;
				end else begin
					slot_vld_q[ptr_s1] <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			op_s1     <= req.op;
			scaled_s1 <= gain_prod[rmsa_pkg::GAIN_SHIFT +: rmsa_pkg::SLOT_W];
			ptr_s1    <= ptr_nxt;
		end
	end

endmodule

// ===== rtl/rmsa_checker.sv =====
// ----------------------------------------------------------------------------
// rmsa_checker
// Port-level checks of the ammeter, bound to the top level.
// ----------------------------------------------------------------------------
module rmsa_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           in_valid,
	input logic                           in_ready,
	input logic                           out_valid,
	input logic                           out_ready,
	input logic [rmsa_pkg::CURRENT_W-1:0] scaled_current,
	input logic                           full_scale,
	input logic [rmsa_pkg::RANGE_W-1:0]   range_select
);

	logic                           in_acc;
	logic                           out_acc;
	logic [1:0]                     inflight_q;
	logic [rmsa_pkg::RANGE_W-1:0]   last_range_q;
	logic [rmsa_pkg::CURRENT_W-1:0] thr;

	assign in_acc  = in_valid && in_ready;
	assign out_acc = out_valid && out_ready;
	assign thr     = rmsa_pkg::CURRENT_W'(rmsa_pkg::scale_of(range_select))
	               * rmsa_pkg::CURRENT_W'(rmsa_pkg::FULL_UNITS);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inflight_q   <= '0;
			last_range_q <= '0;
		end else begin
			inflight_q <= inflight_q + 2'(in_acc) - 2'(out_acc);
			if (out_acc) begin
				last_range_q <= range_select;
			end
		end
	end

	// held result stays put
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(scaled_current)
		&& $stable(range_select))
		else $error("rsp beat changed while stalled");

	// a new range always starts from an empty window
	a_range_clear: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (range_select != last_range_q)
		|-> (scaled_current == '0) && !full_scale)
		else $error("range change without cleared window");

	a_full: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (full_scale == (scaled_current >= thr)))
		else $error("full-scale flag disagrees with current");

	// at most two beats buffered, never a result without a request
	a_inflight: assert property (@(posedge clk) disable iff (!arst_n)
		(inflight_q <= 2'd2) && (!out_valid || (inflight_q != 2'd0)))
		else $error("req/rsp beat count out of step");

endmodule

bind ranged_moving_sum_ammeter_top rmsa_checker u_rmsa_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_valid      (req.valid),
	.in_ready      (req.ready),
	.out_valid     (rsp.valid),
	.out_ready     (rsp.ready),
	.scaled_current(rsp.scaled_current),
	.full_scale    (rsp.full_scale),
	.range_select  (rsp.range_select)
);

// ===== sim/rmsa_scoreboard.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rmsa_scoreboard
// Watches the req and rsp channels of the ranged moving-sum ammeter, keeps its
// own copy of the sample ring, window total and range, predicts one reading
// per accepted req beat and checks each rsp beat against the oldest one.
// ----------------------------------------------------------------------------
module rmsa_scoreboard (
	input  logic clk,
	input  logic arst_n,
	rmsa_req_if  req,
	rmsa_rsp_if  rsp,
	output int   failures,
	output int   pending,
	output int   checked,
	output int   full_hits
);
	import rmsa_pkg::*;

	typedef struct packed {
		logic [CURRENT_W-1:0] current;
		logic                 full;
		range_t               rng;
	} reading_t;

	logic [SLOT_W-1:0]  ring [WINDOW_LEN];
	logic [PTR_W-1:0]   head;
	logic [TOTAL_W-1:0] total;
	range_t             rng;
	reading_t           readings_due [$];

	function automatic reading_t advance_meter(input op_t op, input logic [SAMPLE_W-1:0] raw);
		logic [31:0] level;
		logic [31:0] scale;
		logic [31:0] prod;
		reading_t    r;
		if (op == OP_SAMPLE) begin
			level = (32'(raw) * GAIN) >> GAIN_SHIFT;
			head = (head == PTR_W'(WINDOW_LEN - 1)) ? '0 : head + 1'b1;
			total = total - TOTAL_W'(ring[head]) + TOTAL_W'(level);
			ring[head] = SLOT_W'(level);
		end else begin
			foreach (ring[k])
				ring[k] = '0;
			total = '0;
			rng = range_t'(rng + 1'b1);
		end
		case (rng)
			RANGE_10: scale = 10;
			RANGE_20: scale = 20;
			RANGE_40: scale = 40;
			default:  scale = 50;
		endcase
		prod = 32'(total) * scale;
		r.current = (prod > SCALED_MAX) ? CURRENT_W'(SCALED_MAX) : prod[CURRENT_W-1:0];
		r.full = (32'(total) >= FULL_UNITS);
		r.rng = rng;
		return r;
	endfunction

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("%0t ns mismatch on %s: got %0d, want %0d", $time, what, got, want);
		failures++;
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		reading_t want;
		if (!arst_n) begin
			foreach (ring[k])
				ring[k] = '0;
			head = '0;
			total = '0;
			rng = RANGE_10;
			readings_due.delete();
			failures = 0;
			pending = 0;
			checked = 0;
			full_hits = 0;
		end else begin
			// result first: it belongs to an older req beat than one taken now
			if (rsp.valid && rsp.ready) begin
				if (readings_due.size() == 0) begin
					report_mismatch("rsp beat with nothing pending", rsp.scaled_current, 0);
				end else begin
					want = readings_due.pop_front();
					checked++;
					if (rsp.full_scale)
						full_hits++;
					if (rsp.scaled_current !== want.current)
						report_mismatch("scaled_current", rsp.scaled_current, want.current);
					if (rsp.full_scale !== want.full)
						report_mismatch("full_scale", rsp.full_scale, want.full);
					if (rsp.range_select !== want.rng)
						report_mismatch("range_select", rsp.range_select, want.rng);
				end
			end
			if (req.valid && req.ready)
				readings_due.push_back(advance_meter(op_t'(req.op), req.sample));
			pending = readings_due.size();
		end
	end

endmodule

// ===== sim/ranged_moving_sum_ammeter_top_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ranged_moving_sum_ammeter_top_tb
// Drives converter samples and range steps into the ammeter: a directed run
// over the reading extremes, the full-scale threshold, the largest window and
// the range wrap, then random beats under four mixes of sender idling and
// receiver stalls. A side checker predicts and compares every result.
// ----------------------------------------------------------------------------
module ranged_moving_sum_ammeter_top_tb;
	import rmsa_pkg::*;

	logic clk;
	logic arst_n = 1'b0;

	rmsa_req_if req ();
	rmsa_rsp_if rsp ();

	int failures;
	int pending;
	int checked;
	int full_hits;
	int idle_pct = 0;
	int stall_pct = 0;
	int samples_sent = 0;
	int steps_sent = 0;

	ranged_moving_sum_ammeter_top u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp)
	);

	rmsa_scoreboard u_meter_check (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.rsp       (rsp),
		.failures  (failures),
		.pending   (pending),
		.checked   (checked),
		.full_hits (full_hits)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	always @(negedge clk) begin
		rsp.ready = ($urandom_range(99) >= stall_pct);
	end

	// called at a falling edge; returns at the falling edge after the beat is taken
	task automatic drive_conversion(input op_t op, input logic [SAMPLE_W-1:0] raw);
		int gap;
		gap = 0;
		while ($urandom_range(99) < idle_pct)
			gap++;
		if (gap > 0) begin
			req.valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		req.valid = 1'b1;
		req.op = op;
		req.sample = raw;
		do
			@(posedge clk);
		while (!req.ready);
		@(negedge clk);
		if (op == OP_SAMPLE)
			samples_sent++;
		else
			steps_sent++;
	endtask

	task automatic drain_readings();
		req.valid = 1'b0;
		while (pending != 0)
			@(negedge clk);
	endtask

	task automatic drive_random_beat();
		int pick;
		pick = $urandom_range(99);
		if (pick < 8)
			drive_conversion(OP_RANGE, SAMPLE_W'($urandom_range(1023)));
		else if (pick < 38)
			drive_conversion(OP_SAMPLE, SAMPLE_W'($urandom_range(900, 1023)));
		else if (pick < 46)
			drive_conversion(OP_SAMPLE, ($urandom_range(1)) ? '1 : '0);
		else
			drive_conversion(OP_SAMPLE, SAMPLE_W'($urandom_range(1023)));
	endtask

	initial begin
		req.valid = 1'b0;
		req.op = OP_SAMPLE;
		req.sample = '0;
		rsp.ready = 1'b0;
		repeat (11) @(negedge clk);
		arst_n = 1'b1;

		// extremes and smallest nonzero reading
		drive_conversion(OP_SAMPLE, 10'd0);
		drive_conversion(OP_SAMPLE, 10'd1023);
		drive_conversion(OP_SAMPLE, 10'd11);
		// step up to the 50 range, sample field ignored
		drive_conversion(OP_RANGE, 10'd1023);
		drive_conversion(OP_RANGE, 10'd512);
		drive_conversion(OP_RANGE, 10'd0);
		// full window of top readings, ring wraps
		repeat (8)
			drive_conversion(OP_SAMPLE, 10'd1023);
		// range wraps back to 10
		drive_conversion(OP_RANGE, 10'd341);
		// just below and at the full-scale threshold
		drive_conversion(OP_SAMPLE, 10'd819);
		drive_conversion(OP_RANGE, 10'd682);
		drive_conversion(OP_SAMPLE, 10'd820);
		drive_conversion(OP_SAMPLE, 10'd10);
		drive_conversion(OP_SAMPLE, 10'd1);
		drain_readings();
		repeat (4) @(negedge clk);

		for (int mix = 0; mix < 4; mix++) begin
			case (mix)
				0: begin idle_pct = 0;  stall_pct = 0;  end
				1: begin idle_pct = 62; stall_pct = 0;  end
				2: begin idle_pct = 0;  stall_pct = 62; end
				default: begin idle_pct = 13; stall_pct = 13; end
			endcase
			repeat (100)
				drive_random_beat();
			drain_readings();
		end

		stall_pct = 0;
		repeat (8) @(negedge clk);
		$display("covered %0d samples and %0d range steps under four idle/stall mixes",
			samples_sent, steps_sent);
		$display("%0d readings checked, %0d of them at full scale", checked, full_hits);
		if (failures == 0) begin
			$display("ranged_moving_sum_ammeter_top_tb: clean");
		end else begin
			$display("ranged_moving_sum_ammeter_top_tb: errors");
		end
		$finish;
	end

	initial begin
		#400000;
		$display("ranged_moving_sum_ammeter_top_tb: errors");
		$finish;
	end

endmodule
